// ===== rtl/core/tcp_pkg.sv =====
// shared constants, widths and types for the two-point combined pose pipeline
// used by every module under rtl/core
package tcp_pkg;

  localparam int DATA_W    = 32;
  localparam int LIMIT_W   = 17;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd64880;
  localparam int IN_FIELDS = 12;
  localparam int IN_DATA_W = IN_FIELDS * DATA_W;
  localparam int OUT_DATA_W = 3 * DATA_W;
  localparam int OUT_USER_W = 3;

  localparam int SUM_W  = DATA_W + 1;
  localparam int NV_W   = 35;
  localparam int MAG_W  = NV_W;
  localparam int LEAD_W = 6;
  localparam int NORM_TOP = 29;
  localparam int MS_W   = NORM_TOP + 1;
  localparam int SQS_W  = 2 * MS_W;
  localparam int SQSUM_W = SQS_W + 2;
  localparam int UNIT_W = 18;
  localparam int UMAG_W = UNIT_W - 1;
  localparam int PROD_W = 2 * UNIT_W;
  localparam int DOT_W  = PROD_W + 2;

  localparam int SQRT_STEPS = 34;
  localparam int SQ_IN_W    = 2 * SQRT_STEPS;
  localparam int SQ_ROOT_W  = SQRT_STEPS;
  localparam int SQ_REM_W   = SQ_ROOT_W + 3;

  localparam int DIV_STEPS = 18;
  localparam int DIV_NUM_W = MS_W + 17;
  localparam int DIV_DEN_W = 31;
  localparam int DIV_CMP_W = DIV_DEN_W + DIV_STEPS;

  localparam int DIST_W   = SQ_ROOT_W;
  localparam int DSQ_W    = 2 * DATA_W;
  localparam int DSUM_W   = DSQ_W + 2;
  localparam int SCALE_W  = UMAG_W + DIST_W;
  localparam int RND_W    = SCALE_W + 1;
  localparam int RES_W    = RND_W - 16;

  localparam int NORM_PRE  = 5;
  localparam int NORM_LINE = SQRT_STEPS + DIV_STEPS;
  localparam int NORM_LAT  = NORM_PRE + NORM_LINE + 1;
  localparam int DIST_PAD  = NORM_LAT - 2 - SQRT_STEPS;

  typedef enum logic [1:0] {
    COL_X   = 2'd0,
    COL_Y   = 2'd1,
    COL_Z   = 2'd2,
    COL_MID = 2'd3
  } col_t;

  typedef struct packed {
    logic [2:0][DATA_W-1:0] mid;
    logic [DIST_W-1:0]      span;
    logic [2:0][UNIT_W-1:0] x;
    logic [2:0][UNIT_W-1:0] z;
    logic                   rej;
  } side_t;

endpackage

// ===== rtl/core/tcp_sqrt.sv =====
// pipelined floor square root, one result bit per stage
// depends on tcp_pkg
module tcp_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tcp_pkg::SQ_IN_W-1:0]   rad_i,
  output logic [tcp_pkg::SQ_ROOT_W-1:0] root_o
);
  import tcp_pkg::*;

  logic [SQ_IN_W-1:0]   rad_r  [SQRT_STEPS];
  logic [SQ_REM_W-1:0]  rem_r  [SQRT_STEPS];
  logic [SQ_ROOT_W-1:0] root_r [SQRT_STEPS];

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    logic [SQ_IN_W-1:0]   rad_in;
    logic [SQ_REM_W-1:0]  rem_in;
    logic [SQ_REM_W-1:0]  sh_rem;
    logic [SQ_REM_W-1:0]  trial;
    logic [SQ_ROOT_W-1:0] root_in;
    logic                 take;

    if (g == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
    end

    assign sh_rem = {rem_in[SQ_REM_W-3:0], rad_in[SQ_IN_W-1 -: 2]};
    assign trial  = SQ_REM_W'({root_in, 2'b01});
    assign take   = (sh_rem >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[g]  <= rad_in << 2;
        rem_r[g]  <= take ? (sh_rem - trial) : sh_rem;
        root_r[g] <= {root_in[SQ_ROOT_W-2:0], take};
      end
    end
  end

  assign root_o = root_r[SQRT_STEPS-1];

endmodule

// ===== rtl/core/tcp_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on tcp_pkg
module tcp_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tcp_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [tcp_pkg::DIV_DEN_W-1:0] den_i,
  output logic [tcp_pkg::DIV_STEPS-1:0] q_o
);
  import tcp_pkg::*;

  logic [DIV_NUM_W-1:0] rem_r [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r   [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    localparam int BIT = DIV_STEPS - 1 - g;
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_STEPS-1:0] q_in;
    logic [DIV_CMP_W-1:0] dsh;
    logic                 take;

    if (g == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign q_in   = q_r[g-1];
    end

    assign dsh  = DIV_CMP_W'(den_in) << BIT;
    assign take = (DIV_CMP_W'(rem_in) >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= take ? DIV_NUM_W'(DIV_CMP_W'(rem_in) - dsh) : rem_in;
        den_r[g] <= den_in;
        q_r[g]   <= q_in | (DIV_STEPS'(take) << BIT);
      end
    end
  end

  assign q_o = q_r[DIV_STEPS-1];

endmodule

// ===== rtl/core/tcp_norm.sv =====
// pipelined 3-vector normalizer to a signed 18-bit q1.16 unit vector, zero maps to zero
// depends on tcp_pkg, tcp_sqrt, tcp_div
module tcp_norm (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 vld_i,
  input  logic [2:0][tcp_pkg::NV_W-1:0]        v_i,
  input  tcp_pkg::side_t                       side_i,
  output logic                                 vld_o,
  output logic [2:0][tcp_pkg::UNIT_W-1:0]      u_o,
  output tcp_pkg::side_t                       side_o
);
  import tcp_pkg::*;

  typedef struct packed {
    logic [2:0][MS_W-1:0] ms;
    logic [2:0]           neg;
    logic                 zero;
    side_t                side;
  } nline_t;

  logic [NORM_PRE-1:0]  pre_vld_r;
  logic [NORM_LINE-1:0] line_vld_r;
  logic                 out_vld_r;

  logic [2:0][MAG_W-1:0] mag1_r, mag2_r;
  logic [2:0]            neg1_r, neg2_r, neg3_r, neg4_r, neg5_r;
  side_t                 side1_r, side2_r, side3_r, side4_r, side5_r;
  logic [LEAD_W-1:0]     lead2_r;
  logic                  zero2_r, zero3_r, zero4_r, zero5_r;
  logic [2:0][MS_W-1:0]  ms3_r, ms4_r, ms5_r;
  logic [2:0][SQS_W-1:0] sq4_r;
  logic [SQSUM_W-1:0]    s5_r;
  nline_t                line_r [NORM_LINE];
  logic [2:0][UNIT_W-1:0] u_r;
  side_t                 side_out_r;

  logic [MAG_W-1:0]      orv;
  logic [LEAD_W-1:0]     lead;
  logic [2:0][MS_W-1:0]  ms_nxt;
  logic [SQ_ROOT_W-1:0]  root;
  logic [2:0][DIV_STEPS-1:0] q;
  logic [2:0][UNIT_W-1:0] u_nxt;
  nline_t                line_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r  <= '0;
      line_vld_r <= '0;
      out_vld_r  <= 1'b0;
    end else if (en) begin
      pre_vld_r  <= {pre_vld_r[NORM_PRE-2:0], vld_i};
      line_vld_r <= {line_vld_r[NORM_LINE-2:0], pre_vld_r[NORM_PRE-1]};
      out_vld_r  <= line_vld_r[NORM_LINE-1];
    end
  end

  always_comb begin
    orv  = mag1_r[0] | mag1_r[1] | mag1_r[2];
    lead = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) lead = LEAD_W'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead2_r >= LEAD_W'(NORM_TOP)) begin
        ms_nxt[i] = MS_W'(mag2_r[i] >> (lead2_r - LEAD_W'(NORM_TOP)));
      end else begin
        ms_nxt[i] = MS_W'(mag2_r[i] << (LEAD_W'(NORM_TOP) - lead2_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_r[i] <= v_i[i][NV_W-1];
        mag1_r[i] <= v_i[i][NV_W-1] ? (MAG_W'(0) - v_i[i]) : v_i[i];
      end
      side1_r <= side_i;

      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      lead2_r <= lead;
      zero2_r <= (orv == '0);
      side2_r <= side1_r;

      ms3_r   <= ms_nxt;
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
      side3_r <= side2_r;

      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= SQS_W'(ms3_r[i]) * SQS_W'(ms3_r[i]);
      end
      ms4_r   <= ms3_r;
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
      side4_r <= side3_r;

      s5_r    <= SQSUM_W'(sq4_r[0]) + SQSUM_W'(sq4_r[1]) + SQSUM_W'(sq4_r[2]);
      ms5_r   <= ms4_r;
      neg5_r  <= neg4_r;
      zero5_r <= zero4_r;
      side5_r <= side4_r;
    end
  end

  tcp_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (SQ_IN_W'(s5_r)),
    .root_o (root)
  );

  assign line_in = '{ms: ms5_r, neg: neg5_r, zero: zero5_r, side: side5_r};

  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= line_in;
      for (int i = 1; i < NORM_LINE; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    tcp_div u_div (
      .clk   (clk),
      .en    (en),
      .num_i (DIV_NUM_W'({line_r[SQRT_STEPS-1].ms[l], 16'b0}) + DIV_NUM_W'(root >> 1)),
      .den_i (root[DIV_DEN_W-1:0]),
      .q_o   (q[l])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (line_r[NORM_LINE-1].zero) begin
        u_nxt[i] = '0;
      end else if (line_r[NORM_LINE-1].neg[i]) begin
        u_nxt[i] = UNIT_W'(0) - UNIT_W'(q[i]);
      end else begin
        u_nxt[i] = UNIT_W'(q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r        <= u_nxt;
      side_out_r <= line_r[NORM_LINE-1].side;
    end
  end

  assign vld_o  = out_vld_r;
  assign u_o    = u_r;
  assign side_o = side_out_r;

endmodule

// ===== rtl/core/two_point_combined_pose.sv =====
// two-point combined pose: midpoint origin, axes from a->b and summed up vectors
// the single result register serializes the four columns of each result, so an
// accepted input holds the pipeline until its columns have gone; one input per cycle
// if rejected and out_tready stays high, as a rejected result has one column
// reset: clears all valid bits and loads limit_r with 64880; no memory sweep
// depends on tcp_pkg, tcp_norm, tcp_sqrt
module two_point_combined_pose (
  input  logic                              clk,
  input  logic                              rst_n,
  // a_pos_x,a_pos_y,a_pos_z,b_pos_x,b_pos_y,b_pos_z,a_up_x,a_up_y,a_up_z,b_up_x,b_up_y,b_up_z
  input  logic [tcp_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // elem_0, elem_1, elem_2
  output logic [tcp_pkg::OUT_DATA_W-1:0]    out_tdata,
  // column, pose_ok
  output logic [tcp_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [tcp_pkg::LIMIT_W-1:0]       cfg_wdata
);
  import tcp_pkg::*;

  logic adv;
  logic [LIMIT_W-1:0] limit_r;

  // front stage
  logic                   t1_vld_r;
  logic [2:0][NV_W-1:0]   d_r, up_r;
  logic [2:0][DATA_W-1:0] mid_r;
  logic [2:0][SUM_W-1:0]  d_nxt, up_nxt, ab_nxt;

  // distance path
  logic [2:0][DSQ_W-1:0]  dsq_r;
  logic [DSUM_W-1:0]      dsum_r;
  logic [DIST_W-1:0]      dist_root;
  logic [DIST_W-1:0]      dpad_r [DIST_PAD];

  // first normalize
  logic                   nx_vld, nyp_vld;
  logic [2:0][UNIT_W-1:0] ux, uyp;
  side_t                  nx_side, side_in;

  // dot and first cross
  logic                   p1_vld_r, p2_vld_r;
  logic signed [PROD_W-1:0] pd_r [3];
  logic signed [PROD_W-1:0] pc_r [6];
  side_t                  p1_side_r, p2_side_r;
  logic [2:0][NV_W-1:0]   t_r;
  logic signed [DOT_W-1:0] dot;
  logic [DOT_W-1:0]       adot;

  // second normalize and cross
  logic                   nz_vld, q1_vld_r, q2_vld_r;
  logic [2:0][UNIT_W-1:0] uz;
  side_t                  nz_side, q1_side_r, q2_side_r;
  logic signed [PROD_W-1:0] qc_r [6];
  logic [2:0][NV_W-1:0]   t2_r;

  // third normalize and scaling
  logic                   ny_vld, s1_vld_r, s2_vld_r;
  logic [2:0][UNIT_W-1:0] uy;
  side_t                  ny_side;
  logic [8:0][SCALE_W-1:0] sc_r;
  logic [8:0]             sneg_r;
  logic [2:0][DATA_W-1:0] s1_mid_r, s2_mid_r;
  logic                   s1_rej_r, s2_rej_r;
  logic [8:0][DATA_W-1:0] sat_r;
  logic [8:0][DATA_W-1:0] sat_nxt;
  logic [8:0][UNIT_W-1:0] axes;

  // result serializer
  logic                   ser_vld_r, ser_rej_r;
  col_t                   col_r;
  logic [3:0][2:0][DATA_W-1:0] cols_r;
  logic                   out_fire, ser_last, ser_take;

  assign out_fire = ser_vld_r && out_tready;
  assign ser_last = ser_rej_r || (col_r == COL_MID);
  assign ser_take = !ser_vld_r || (out_fire && ser_last);
  assign adv      = !s2_vld_r || ser_take;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab_nxt[i] = {in_tdata[32*i+31], in_tdata[32*i +: 32]}
                + {in_tdata[32*(3+i)+31], in_tdata[32*(3+i) +: 32]};
      d_nxt[i]  = {in_tdata[32*(3+i)+31], in_tdata[32*(3+i) +: 32]}
                - {in_tdata[32*i+31], in_tdata[32*i +: 32]};
      up_nxt[i] = {in_tdata[32*(6+i)+31], in_tdata[32*(6+i) +: 32]}
                + {in_tdata[32*(9+i)+31], in_tdata[32*(9+i) +: 32]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      q1_vld_r <= 1'b0;
      q2_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      t1_vld_r <= in_tvalid;
      p1_vld_r <= nx_vld;
      p2_vld_r <= p1_vld_r;
      q1_vld_r <= nz_vld;
      q2_vld_r <= q1_vld_r;
      s1_vld_r <= ny_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= {{(NV_W-SUM_W){d_nxt[i][SUM_W-1]}}, d_nxt[i]};
        up_r[i]  <= {{(NV_W-SUM_W){up_nxt[i][SUM_W-1]}}, up_nxt[i]};
        mid_r[i] <= ab_nxt[i][SUM_W-1:1];
      end
    end
  end

  // distance: exact sum of squares, then floor root, then padded to the axis timing
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dsq_r[i] <= DSQ_W'(d_r[i][NV_W-1] ? DATA_W'(SUM_W'(0) - SUM_W'(d_r[i]))
                                          : DATA_W'(d_r[i]))
                  * DSQ_W'(d_r[i][NV_W-1] ? DATA_W'(SUM_W'(0) - SUM_W'(d_r[i]))
                                          : DATA_W'(d_r[i]));
      end
      dsum_r <= DSUM_W'(dsq_r[0]) + DSUM_W'(dsq_r[1]) + DSUM_W'(dsq_r[2]);
      dpad_r[0] <= dist_root;
      for (int i = 1; i < DIST_PAD; i++) begin
        dpad_r[i] <= dpad_r[i-1];
      end
    end
  end

  tcp_sqrt u_dist_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad_i  (SQ_IN_W'(dsum_r)),
    .root_o (dist_root)
  );

  always_comb begin
    side_in     = '0;
    side_in.mid = mid_r;
  end

  tcp_norm u_norm_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (t1_vld_r),
    .v_i    (d_r),
    .side_i (side_in),
    .vld_o  (nx_vld),
    .u_o    (ux),
    .side_o (nx_side)
  );

  tcp_norm u_norm_yp (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (t1_vld_r),
    .v_i    (up_r),
    .side_i ('0),
    .vld_o  (nyp_vld),
    .u_o    (uyp),
    .side_o ()
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pd_r[i] <= $signed(ux[i]) * $signed(uyp[i]);
      end
      pc_r[0] <= $signed(ux[1]) * $signed(uyp[2]);
      pc_r[1] <= $signed(ux[2]) * $signed(uyp[1]);
      pc_r[2] <= $signed(ux[2]) * $signed(uyp[0]);
      pc_r[3] <= $signed(ux[0]) * $signed(uyp[2]);
      pc_r[4] <= $signed(ux[0]) * $signed(uyp[1]);
      pc_r[5] <= $signed(ux[1]) * $signed(uyp[0]);
      p1_side_r <= '{mid: nx_side.mid, span: dpad_r[DIST_PAD-1], x: ux,
                     z: nx_side.z, rej: nx_side.rej};
    end
  end

  assign dot  = DOT_W'(pd_r[0]) + DOT_W'(pd_r[1]) + DOT_W'(pd_r[2]);
  assign adot = dot[DOT_W-1] ? DOT_W'(DOT_W'(0) - dot) : DOT_W'(dot);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t_r[i] <= NV_W'((PROD_W+1)'(pc_r[2*i]) - (PROD_W+1)'(pc_r[2*i+1]));
      end
      p2_side_r <= '{mid: p1_side_r.mid, span: p1_side_r.span, x: p1_side_r.x,
                     z: p1_side_r.z, rej: (adot > DOT_W'({limit_r, 16'b0}))};
    end
  end

  tcp_norm u_norm_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (p2_vld_r),
    .v_i    (t_r),
    .side_i (p2_side_r),
    .vld_o  (nz_vld),
    .u_o    (uz),
    .side_o (nz_side)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      qc_r[0] <= $signed(uz[1]) * $signed(nz_side.x[2]);
      qc_r[1] <= $signed(uz[2]) * $signed(nz_side.x[1]);
      qc_r[2] <= $signed(uz[2]) * $signed(nz_side.x[0]);
      qc_r[3] <= $signed(uz[0]) * $signed(nz_side.x[2]);
      qc_r[4] <= $signed(uz[0]) * $signed(nz_side.x[1]);
      qc_r[5] <= $signed(uz[1]) * $signed(nz_side.x[0]);
      q1_side_r <= '{mid: nz_side.mid, span: nz_side.span, x: nz_side.x,
                     z: uz, rej: nz_side.rej};
      for (int i = 0; i < 3; i++) begin
        t2_r[i] <= NV_W'((PROD_W+1)'(qc_r[2*i]) - (PROD_W+1)'(qc_r[2*i+1]));
      end
      q2_side_r <= q1_side_r;
    end
  end

  tcp_norm u_norm_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (q2_vld_r),
    .v_i    (t2_r),
    .side_i (q2_side_r),
    .vld_o  (ny_vld),
    .u_o    (uy),
    .side_o (ny_side)
  );

  assign axes = {ny_side.z, uy, ny_side.x};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        sneg_r[k] <= axes[k][UNIT_W-1];
        sc_r[k]   <= SCALE_W'(axes[k][UNIT_W-1] ? UMAG_W'(UNIT_W'(0) - axes[k])
                                               : UMAG_W'(axes[k]))
                   * SCALE_W'(ny_side.span);
      end
      s1_mid_r <= ny_side.mid;
      s1_rej_r <= ny_side.rej;
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      logic [RES_W-1:0] r;
      r = RES_W'((RND_W'(sc_r[k]) + RND_W'(32768)) >> 16);
      if (sneg_r[k]) begin
        if (r > RES_W'(33'h080000000)) r = RES_W'(33'h080000000);
        sat_nxt[k] = DATA_W'(RES_W'(0) - r);
      end else begin
        if (r > RES_W'(32'h7fffffff)) r = RES_W'(32'h7fffffff);
        sat_nxt[k] = DATA_W'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sat_r    <= sat_nxt;
      s2_mid_r <= s1_mid_r;
      s2_rej_r <= s1_rej_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      col_r     <= COL_X;
    end else if (ser_take) begin
      ser_vld_r <= s2_vld_r;
      col_r     <= COL_X;
    end else if (out_fire) begin
      case (col_r)
        COL_X:   col_r <= COL_Y;
        COL_Y:   col_r <= COL_Z;
        COL_Z:   col_r <= COL_MID;
        default: col_r <= COL_X;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      cols_r[0] <= sat_r[2:0];
      cols_r[1] <= sat_r[5:3];
      cols_r[2] <= sat_r[8:6];
      cols_r[3] <= s2_mid_r;
      ser_rej_r <= s2_rej_r;
    end
  end

  always_comb begin
    out_tdata = '0;
    if (!ser_rej_r) begin
      case (col_r)
        COL_X:   out_tdata = cols_r[0];
        COL_Y:   out_tdata = cols_r[1];
        COL_Z:   out_tdata = cols_r[2];
        COL_MID: out_tdata = cols_r[3];
        default: out_tdata = '0;
      endcase
    end
  end

  assign out_tuser  = {!ser_rej_r, col_r};
  assign out_tlast  = ser_last;
  assign out_tvalid = ser_vld_r;

endmodule

// ===== dv/two_point_combined_pose_tb.sv =====
// testbench for two_point_combined_pose: random and directed point pairs, checked per column
// against a fixed-point pose predictor in a scoreboard class; depends on tcp_pkg and the rtl
module two_point_combined_pose_tb;
  import tcp_pkg::*;

  typedef struct {
    logic [1:0]  column;
    logic [31:0] e0, e1, e2;
    logic        ok, last;
  } col_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic out_tlast, out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  int errors = 0;
  int idle_cycles = 0;
  int n_items = 0, n_rej = 0, n_cols = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  two_point_combined_pose u_top (
    .clk(clk), .rst_n(rst_n), .in_tdata(in_tdata), .in_tvalid(in_tvalid),
    .in_tready(in_tready), .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tlast(out_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  class pose_scoreboard;
    logic [16:0] limit;
    col_rec_t pending[$];

    function new();
      limit = LIMIT_RESET;
    endfunction

    function automatic logic [63:0] root68(logic [67:0] v);
      logic [67:0] rem, trial;
      logic [63:0] r;
      rem = 0; r = 0;
      for (int i = 33; i >= 0; i--) begin
        rem = (rem << 2) | ((v >> (2 * i)) & 68'd3);
        trial = ({4'd0, r} << 2) | 68'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          r = (r << 1) | 64'd1;
        end else begin
          r = r << 1;
        end
      end
      return r;
    endfunction

    function automatic void unitize(input longint v[3], output longint u[3]);
      logic [63:0] m[3], mx, s, n, q;
      mx = 0; s = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = v[i] < 0 ? -v[i] : v[i];
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
        u = '{0, 0, 0};
        return;
      end
      while (mx >= 64'd1 << 30) begin
        for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        mx = mx >> 1;
      end
      while (mx < 64'd1 << 29) begin
        for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        mx = mx << 1;
      end
      for (int i = 0; i < 3; i++) s += m[i] * m[i];
      n = root68({4'd0, s});
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << 16) + (n >> 1)) / n;
        u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
    endfunction

    function automatic void cross_prod(input longint a[3], input longint b[3],
                                       output longint c[3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic [31:0] scaled(longint ax, logic [63:0] span);
      logic [63:0] r;
      logic [63:0] m;
      m = ax < 0 ? -ax : ax;
      r = (m * span + 64'd32768) >> 16;
      if (ax < 0) begin
        if (r > 64'h8000_0000) r = 64'h8000_0000;
        return 32'(-r);
      end
      if (r > 64'h7fff_ffff) r = 64'h7fff_ffff;
      return r[31:0];
    endfunction

    function automatic void note_input(logic [IN_DATA_W-1:0] d);
      longint a[3], b[3], dv[3], up[3], x[3], yp[3], z[3], y[3], t[3], dot;
      logic [31:0] mid[3];
      logic [67:0] sq;
      logic [63:0] span, md;
      col_rec_t c;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = longint'($signed(d[32 * i +: 32]));
        b[i] = longint'($signed(d[32 * (3 + i) +: 32]));
        up[i] = longint'($signed(d[32 * (6 + i) +: 32])) +
                longint'($signed(d[32 * (9 + i) +: 32]));
        dv[i] = b[i] - a[i];
        mid[i] = 32'((a[i] + b[i]) >>> 1);
        md = dv[i] < 0 ? -dv[i] : dv[i];
        sq += {4'd0, md} * {4'd0, md};
      end
      span = root68(sq);
      unitize(dv, x);
      unitize(up, yp);
      dot = x[0] * yp[0] + x[1] * yp[1] + x[2] * yp[2];
      if (dot < 0) dot = -dot;
      if (dot > (longint'(limit) << 16)) begin
        c = '{COL_X, 0, 0, 0, 1'b0, 1'b1};
        pending.push_back(c);
        n_rej++;
        return;
      end
      cross_prod(x, yp, t);
      unitize(t, z);
      cross_prod(z, x, t);
      unitize(t, y);
      for (int k = 0; k < 4; k++) begin
        c.column = k[1:0];
        c.ok = 1'b1;
        c.last = (k == 3);
        case (col_t'(k))
          COL_X: begin
            c.e0 = scaled(x[0], span); c.e1 = scaled(x[1], span); c.e2 = scaled(x[2], span);
          end
          COL_Y: begin
            c.e0 = scaled(y[0], span); c.e1 = scaled(y[1], span); c.e2 = scaled(y[2], span);
          end
          COL_Z: begin
            c.e0 = scaled(z[0], span); c.e1 = scaled(z[1], span); c.e2 = scaled(z[2], span);
          end
          default: begin
            c.e0 = mid[0]; c.e1 = mid[1]; c.e2 = mid[2];
          end
        endcase
        pending.push_back(c);
      end
    endfunction

    task automatic check_column(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u, logic l);
      col_rec_t w;
      if (pending.size() == 0) begin
        report("unexpected column", d[31:0], 0);
        return;
      end
      w = pending.pop_front();
      if (u[1:0] !== w.column) report("column", u[1:0], w.column);
      if (d[31:0] !== w.e0) report("elem_0", d[31:0], w.e0);
      if (d[63:32] !== w.e1) report("elem_1", d[63:32], w.e1);
      if (d[95:64] !== w.e2) report("elem_2", d[95:64], w.e2);
      if (u[2] !== w.ok) report("pose_ok", u[2], w.ok);
      if (l !== w.last) report("tlast", l, w.last);
    endtask
  endclass

  pose_scoreboard sb = new();

  // receiver stalls on its own pattern, with calm stretches
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_column(out_tdata, out_tuser, out_tlast);
      n_cols++;
    end
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(input logic [IN_DATA_W-1:0] d);
    in_tdata <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(d);
    n_items++;
  endtask

  task automatic idle();
    in_tvalid <= 1'b0;
  endtask

  task automatic gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (g > 0) idle();
    repeat (g) @(posedge clk);
  endtask

  task automatic drain();
    idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.limit = v;
  endtask

  function automatic logic [IN_DATA_W-1:0] pack(input int f[12]);
    logic [IN_DATA_W-1:0] d;
    for (int i = 0; i < 12; i++) d[32 * i +: 32] = f[i];
    return d;
  endfunction

  function automatic int rnd_val(int scale);
    case (scale)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h7_ffff)) - 32'h4_0000;
      2: return ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
      default: return $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  task automatic random_pose();
    int f[12];
    int sc;
    sc = $urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3);
    for (int i = 0; i < 12; i++) f[i] = ($urandom_range(0, 9) == 0) ? rnd_val(2) : rnd_val(sc);
    if ($urandom_range(0, 9) == 0) for (int i = 0; i < 3; i++) f[3 + i] = f[i];
    if ($urandom_range(0, 9) == 0) for (int i = 0; i < 3; i++) f[9 + i] = -f[6 + i];
    // up vector along a->b, pushes toward rejection
    if ($urandom_range(0, 7) == 0)
      for (int i = 0; i < 3; i++) begin
        f[6 + i] = f[3 + i] - f[i] + rnd_val(3);
        f[9 + i] = f[6 + i];
      end
    send(pack(f));
  endtask

  initial begin
    int burst;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: axis-aligned, coincident, parallel, extremes
    send(pack('{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0}));
    send(pack('{0, 0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000}));
    send(pack('{0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0}));
    send(pack('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send(pack('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff,
                32'h8000_0000, 1}));
    send(pack('{32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000}));
    send(pack('{-1, -1, -1, 1, 1, 1, 0, 1, 0, 0, 1, 0}));
    send(pack('{0, 0, 0, 32'hfff0_0000, 32'h0800, 0, 32'h0100, 32'h10000, 0, 0, 32'h10000, 0}));
    send(pack('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}));
    for (int i = 0; i < 6; i++) random_pose();
    set_limit(17'd0);
    for (int i = 0; i < 4; i++) random_pose();
    send(pack('{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0}));
    set_limit(17'h1ffff);
    send(pack('{0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0}));
    set_limit(17'd65536);
    send(pack('{0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0}));
    set_limit(17'd46341);
    // random bursts with gaps, limit changed a few times
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < 40; n += burst) begin
        burst = $urandom_range(1, 10);
        for (int j = 0; j < burst; j++) random_pose();
        if ($urandom_range(0, 7) == 0) drain();
        else gap();
      end
      set_limit(ph == 1 ? LIMIT_RESET : LIMIT_W'($urandom_range(0, 17'h1ffff)));
    end
    drain();
    $display("sent %0d point pairs, %0d rejected, %0d columns checked", n_items, n_rej, n_cols);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/tcp_pkg.sv
rtl/core/tcp_sqrt.sv
rtl/core/tcp_div.sv
rtl/core/tcp_norm.sv
rtl/core/two_point_combined_pose.sv
dv/two_point_combined_pose_tb.sv
